// File: rtl/nlp_pkg.sv
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared types and constants for the nearest live point search block.
// ----------------------------------------------------------------------------
package nlp_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int COORD_W     = 16;
    localparam int KEY_W       = 32;
    localparam int COUNT_W     = 16;
    localparam int RAD_W       = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
    localparam int DIST_W      = COORD_W + 1;
    localparam int CMP_W       = (COORD_W > RAD_W) ? COORD_W : RAD_W;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] STAT_QUERY_DONE = 2'd0;
    localparam logic [1:0] STAT_UPDATED    = 2'd1;
    localparam logic [1:0] STAT_APPENDED   = 2'd2;
    localparam logic [1:0] STAT_FULL       = 2'd3;

    typedef struct packed {
        logic                        operation;
        logic [KEY_W-1:0]            entry_key;
        logic signed [COORD_W-1:0]   entry_x;
        logic signed [COORD_W-1:0]   entry_y;
        logic signed [COUNT_W-1:0]   entry_count;
        logic signed [COORD_W-1:0]   query_x;
        logic signed [COORD_W-1:0]   query_y;
        logic [RAD_W-1:0]            search_radius;
    } req_t;

    typedef struct packed {
        logic                        found;
        logic signed [COORD_W-1:0]   best_x;
        logic signed [COORD_W-1:0]   best_y;
        logic [1:0]                  status;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]            key;
        logic signed [COORD_W-1:0]   x;
        logic signed [COORD_W-1:0]   y;
        logic signed [COUNT_W-1:0]   count;
    } entry_t;

    typedef struct packed {
        logic                        clear;
        logic                        valid;
        logic [IDX_W-1:0]            idx;
    } scan_ctl_t;

    typedef struct packed {
        logic                        busy;
        logic                        hit;
        logic [IDX_W-1:0]            hit_idx;
        logic                        found;
        logic signed [COORD_W-1:0]   best_x;
        logic signed [COORD_W-1:0]   best_y;
    } scan_res_t;

endpackage

// File: rtl/nlp_ram.sv
// ----------------------------------------------------------------------------
// nlp_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module nlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/nlp_eval.sv
// ----------------------------------------------------------------------------
// nlp_eval
// Two-stage per-entry evaluator: distance, radius and key match, then
// running best and first key hit.
// ----------------------------------------------------------------------------
module nlp_eval (
    input  logic              clk,
    input  logic              rst_n,
    input  nlp_pkg::scan_ctl_t ctl,
    input  nlp_pkg::entry_t   rd_data,
    input  nlp_pkg::req_t     req,
    output nlp_pkg::scan_res_t res
);
    import nlp_pkg::*;

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] df;
        begin
            df = {a[COORD_W-1], a} - {b[COORD_W-1], b};
            if (df[COORD_W])
            begin
                df = -df;
            end
            return df[COORD_W-1:0];
        end
    endfunction

    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               in_rad;
    logic               live;

    logic                      a_valid_reg;
    logic                      a_ok_reg;
    logic                      a_keq_reg;
    logic [DIST_W-1:0]         a_d_reg;
    logic signed [COORD_W-1:0] a_x_reg;
    logic signed [COORD_W-1:0] a_y_reg;
    logic [IDX_W-1:0]          a_idx_reg;

    logic                      have_reg;
    logic                      hit_reg;
    logic [DIST_W-1:0]         best_d_reg;
    logic signed [COORD_W-1:0] best_x_reg;
    logic signed [COORD_W-1:0] best_y_reg;
    logic [IDX_W-1:0]          hit_idx_reg;

    logic take;
    logic khit;

    always_comb
    begin
        dx     = abs_diff(rd_data.x, req.query_x);
        dy     = abs_diff(rd_data.y, req.query_y);
        in_rad = (CMP_W'(dx) <= CMP_W'(req.search_radius)) &&
                 (CMP_W'(dy) <= CMP_W'(req.search_radius));
        live   = !rd_data.count[COUNT_W-1] && (rd_data.count != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= ctl.valid && !ctl.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ok_reg  <= live && in_rad;
        a_keq_reg <= (rd_data.key == req.entry_key);
        a_d_reg   <= DIST_W'(dx) + DIST_W'(dy);
        a_x_reg   <= rd_data.x;
        a_y_reg   <= rd_data.y;
        a_idx_reg <= ctl.idx;
    end

    assign take = a_valid_reg && a_ok_reg && (!have_reg || (a_d_reg < best_d_reg));
    assign khit = a_valid_reg && a_keq_reg && !hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else if (ctl.clear)
        begin
            have_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                have_reg <= 1'b1;
            end
            if (khit)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            best_x_reg <= '0;
            best_y_reg <= '0;
        end
        else if (take)
        begin
            best_d_reg <= a_d_reg;
            best_x_reg <= a_x_reg;
            best_y_reg <= a_y_reg;
        end
        if (khit)
        begin
            hit_idx_reg <= a_idx_reg;
        end
    end

    always_comb
    begin
        res.busy    = a_valid_reg;
        res.hit     = hit_reg;
        res.hit_idx = hit_idx_reg;
        res.found   = have_reg;
        res.best_x  = best_x_reg;
        res.best_y  = best_y_reg;
    end

endmodule

// File: rtl/nearest_live_point_in_radius.sv
// ----------------------------------------------------------------------------
// nearest_live_point_in_radius
// A request is accepted only in idle; the table is read one entry per cycle
// through the single RAM port, the evaluator drains, and the result is loaded
// once the response register is free, which a response stall can hold off.
// No new request is taken until then; an update writes back at most once.
// Reset: asynchronous active low; clears occupancy and control, table contents
// stay undefined and are only read below occupancy.
// ----------------------------------------------------------------------------
module nearest_live_point_in_radius (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  nlp_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output nlp_pkg::rsp_t rsp_data
);
    import nlp_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]       state_reg,  state_next;
    logic [OCC_W-1:0] occ_reg,    occ_next;
    logic [OCC_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             p1_valid_reg;
    logic [IDX_W-1:0] p1_idx_reg;
    req_t             req_reg;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg,       rsp_next;

    logic       accept;
    logic       rd_en;
    logic       we;
    logic       load;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] wr_addr;
    entry_t     wdata;
    entry_t     rdata;
    scan_ctl_t  ctl;
    scan_res_t  res;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign load      = (state_reg == ST_FINISH) && (!rsp_valid_reg || !rsp_stall);
    assign rd_en     = (state_reg == ST_SCAN) && (rd_cnt_reg < occ_reg);

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        rd_cnt_next    = rd_cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        we             = 1'b0;
        wr_addr        = res.hit ? res.hit_idx : occ_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_cnt_next = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!p1_valid_reg && !res.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    rsp_next       = '0;
                    if (req_reg.operation == OP_QUERY)
                    begin
                        rsp_next.found  = res.found;
                        rsp_next.best_x = res.best_x;
                        rsp_next.best_y = res.best_y;
                        rsp_next.status = STAT_QUERY_DONE;
                    end
                    else if (res.hit)
                    begin
                        we              = 1'b1;
                        rsp_next.status = STAT_UPDATED;
                    end
                    else if (occ_reg < OCC_W'(MAX_ENTRIES))
                    begin
                        we              = 1'b1;
                        occ_next        = occ_reg + 1'b1;
                        rsp_next.status = STAT_APPENDED;
                    end
                    else
                    begin
                        rsp_next.status = STAT_FULL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            rd_cnt_reg    <= '0;
            p1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            rd_cnt_reg    <= rd_cnt_next;
            p1_valid_reg  <= rd_en;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_data;
        end
        p1_idx_reg <= rd_cnt_reg[IDX_W-1:0];
        rsp_reg    <= rsp_next;
    end

    assign addr        = we ? wr_addr : rd_cnt_reg[IDX_W-1:0];
    assign wdata.key   = req_reg.entry_key;
    assign wdata.x     = req_reg.entry_x;
    assign wdata.y     = req_reg.entry_y;
    assign wdata.count = req_reg.entry_count;

    nlp_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .re    (rd_en),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign ctl.clear = accept;
    assign ctl.valid = p1_valid_reg;
    assign ctl.idx   = p1_idx_reg;

    nlp_eval u_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rd_data (rdata),
        .req     (req_reg),
        .res     (res)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(MAX_ENTRIES))
        else $error("occupancy above table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (rd_cnt_reg < occ_reg) && !we)
        else $error("read beyond occupancy or during write");

    assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == ST_FINISH) && !p1_valid_reg && !res.busy)
        else $error("write while scan in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        (load && (rsp_next.status == STAT_FULL)) |-> (occ_reg == OCC_W'(MAX_ENTRIES)))
        else $error("table full reported below capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (load && (rsp_next.status == STAT_APPENDED)) |=> (occ_reg == $past(occ_reg) + 1'b1))
        else $error("append did not grow occupancy");

endmodule

// File: dv/tb_nearest_live_point_in_radius.sv
// ----------------------------------------------------------------------------
// tb_nearest_live_point_in_radius
// Self-checking bench for the keyed point table. A directed list of requests
// covers the corner coordinates, dead counts, ties and radius edges. Random
// requests then grow the table until it is full and keep going against it.
// Every response is compared with a table model kept inside the bench, or with the answer typed in a directed row.
// Both handshake sides idle at random, and the response side holds off once
// for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_nearest_live_point_in_radius;
    import nlp_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int HOLD_ITEM    = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE1_ITEMS = 900;
    localparam int PHASE3_ITEMS = 430;

    typedef struct {
        req_t req;
        bit   typed;
        rsp_t answer;
    } row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_data;

    logic [KEY_W-1:0] tbl_key [MAX_ENTRIES];
    int               tbl_x   [MAX_ENTRIES];
    int               tbl_y   [MAX_ENTRIES];
    int               tbl_cnt [MAX_ENTRIES];
    int               tbl_used = 0;

    rsp_t answers_due[$];
    row_t directed_rows[$];
    int   mismatch_count = 0;
    int   items_sent = 0;
    int   rsp_count = 0;
    int   cycle_count = 0;
    bit   no_idle = 1'b0;

    nearest_live_point_in_radius DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // table model: apply one request, return the response it should produce
    function automatic rsp_t compute_answer(input req_t r);
        rsp_t a;
        int   i;
        int   slot;
        int   qx;
        int   qy;
        int   rad;
        int   dx;
        int   dy;
        int   d;
        int   best;
        bit   have;
        a    = '0;
        slot = -1;
        best = 0;
        have = 1'b0;
        if (r.operation == OP_UPDATE)
        begin
            for (i = 0; i < tbl_used; i++)
                if (slot < 0 && tbl_key[i] == r.entry_key)
                    slot = i;
            if (slot >= 0)
                a.status = STAT_UPDATED;
            else if (tbl_used < MAX_ENTRIES)
            begin
                slot = tbl_used;
                tbl_used++;
                a.status = STAT_APPENDED;
            end
            else
                a.status = STAT_FULL;
            if (slot >= 0)
            begin
                tbl_key[slot] = r.entry_key;
                tbl_x[slot]   = int'($signed(r.entry_x));
                tbl_y[slot]   = int'($signed(r.entry_y));
                tbl_cnt[slot] = int'($signed(r.entry_count));
            end
        end
        else
        begin
            qx  = int'($signed(r.query_x));
            qy  = int'($signed(r.query_y));
            rad = int'(r.search_radius);
            for (i = 0; i < tbl_used; i++)
            begin
                if (tbl_cnt[i] > 0)
                begin
                    dx = tbl_x[i] - qx;
                    dy = tbl_y[i] - qy;
                    if (dx < 0)
                        dx = -dx;
                    if (dy < 0)
                        dy = -dy;
                    d = dx + dy;
                    if (dx <= rad && dy <= rad && (!have || d < best))
                    begin
                        have     = 1'b1;
                        best     = d;
                        a.best_x = COORD_W'(tbl_x[i]);
                        a.best_y = COORD_W'(tbl_y[i]);
                    end
                end
            end
            a.found  = have;
            a.status = STAT_QUERY_DONE;
        end
        return a;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 19))
            0, 1, 2: return COORD_W'($urandom);
            3:       return COORD_W'(-32768);
            4:       return COORD_W'(32767);
            default: return COORD_W'($urandom_range(0, 255) - 128);
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] rand_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COUNT_W'($urandom);
            2:       return COUNT_W'(-int'($urandom_range(1, 40)));
            default: return COUNT_W'($urandom_range(1, 50));
        endcase
    endfunction

    function automatic logic [RAD_W-1:0] rand_radius();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return RAD_W'($urandom);
            default: return RAD_W'($urandom_range(0, 300));
        endcase
    endfunction

    function automatic req_t random_request(input int fresh_pct, input int query_pct);
        req_t r;
        r.operation = ($urandom_range(0, 99) < query_pct) ? OP_QUERY : OP_UPDATE;
        r.entry_key = $urandom;
        if (tbl_used > 0 && $urandom_range(0, 99) >= fresh_pct)
            r.entry_key = tbl_key[$urandom_range(0, tbl_used - 1)];
        r.entry_x       = rand_coord();
        r.entry_y       = rand_coord();
        r.entry_count   = rand_count();
        r.query_x       = rand_coord();
        r.query_y       = rand_coord();
        r.search_radius = rand_radius();
        return r;
    endfunction

    function automatic void add_row(input logic op, input logic [KEY_W-1:0] key,
                                    input int x, input int y, input int cnt,
                                    input int qx, input int qy, input int rad,
                                    input bit typed, input bit fnd, input int ex,
                                    input int ey, input logic [1:0] st);
        row_t row;
        row.req.operation     = op;
        row.req.entry_key     = key;
        row.req.entry_x       = COORD_W'(x);
        row.req.entry_y       = COORD_W'(y);
        row.req.entry_count   = COUNT_W'(cnt);
        row.req.query_x       = COORD_W'(qx);
        row.req.query_y       = COORD_W'(qy);
        row.req.search_radius = RAD_W'(rad);
        row.typed             = typed;
        row.answer.found      = fnd;
        row.answer.best_x     = COORD_W'(ex);
        row.answer.best_y     = COORD_W'(ey);
        row.answer.status     = st;
        directed_rows = {directed_rows, row};
    endfunction

    task automatic drive_req(input req_t r, input bit typed, input rsp_t typed_answer);
        int   gap;
        rsp_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        items_sent++;
        predicted = compute_answer(r);
        answers_due = {answers_due, (typed ? typed_answer : predicted)};
    endtask

    task automatic log_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            rsp_count++;
            if (answers_due.size() == 0)
                log_mismatch($sformatf("response with nothing pending: %p", rsp_data));
            else
            begin
                want = answers_due.pop_front();
                if (rsp_data.found !== want.found)
                    log_mismatch($sformatf("found %0b, want %0b", rsp_data.found, want.found));
                if (rsp_data.best_x !== want.best_x)
                    log_mismatch($sformatf("best_x %0d, want %0d",
                                           rsp_data.best_x, want.best_x));
                if (rsp_data.best_y !== want.best_y)
                    log_mismatch($sformatf("best_y %0d, want %0d",
                                           rsp_data.best_y, want.best_y));
                if (rsp_data.status !== want.status)
                    log_mismatch($sformatf("status %0d, want %0d",
                                           rsp_data.status, want.status));
            end
        end
    end

    // response side: random wait after each response, one long hold-off
    initial
    begin : rsp_side
        int stall_left;
        int seen;
        bit held;
        stall_left = 0;
        seen       = 0;
        held       = 1'b0;
        rsp_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_count != seen)
            begin
                seen       = rsp_count;
                stall_left = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (!held && items_sent == HOLD_ITEM)
            begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial
    begin : stimulus
        int i;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_row(OP_QUERY,  32'h0, 0, 0, 0, 0, 0, 65535, 1, 0, 0, 0, STAT_QUERY_DONE);
        add_row(OP_UPDATE, 32'h0, -32768, -32768, 1, 0, 0, 0, 1, 0, 0, 0, STAT_APPENDED);
        add_row(OP_UPDATE, 32'hFFFF_FFFF, 32767, 32767, 32767, 0, 0, 0,
                1, 0, 0, 0, STAT_APPENDED);
        add_row(OP_QUERY,  32'h0, 0, 0, 0, 32767, 32767, 0,
                1, 1, 32767, 32767, STAT_QUERY_DONE);
        add_row(OP_QUERY,  32'h0, 0, 0, 0, -32768, -32768, 0,
                1, 1, -32768, -32768, STAT_QUERY_DONE);
        // equal distance to both corners: earlier entry wins
        add_row(OP_QUERY,  32'h0, 0, 0, 0, 32767, -32768, 65535,
                1, 1, -32768, -32768, STAT_QUERY_DONE);
        add_row(OP_QUERY,  32'h0, 0, 0, 0, 32767, -32768, 65534,
                1, 0, 0, 0, STAT_QUERY_DONE);
        add_row(OP_UPDATE, 32'h0, -32768, -32768, 0, 0, 0, 0, 1, 0, 0, 0, STAT_UPDATED);
        add_row(OP_QUERY,  32'h0, 0, 0, 0, -32768, -32768, 65535,
                1, 1, 32767, 32767, STAT_QUERY_DONE);
        add_row(OP_UPDATE, 32'hFFFF_FFFF, 32767, 32767, -32768, 0, 0, 0,
                1, 0, 0, 0, STAT_UPDATED);
        add_row(OP_QUERY,  32'h0, 0, 0, 0, 0, 0, 65535, 1, 0, 0, 0, STAT_QUERY_DONE);
        add_row(OP_UPDATE, 32'h1, 5, 5, 1, 0, 0, 0, 1, 0, 0, 0, STAT_APPENDED);
        add_row(OP_UPDATE, 32'h2, -5, -5, 2, 0, 0, 0, 1, 0, 0, 0, STAT_APPENDED);
        add_row(OP_QUERY,  32'h0, 0, 0, 0, 0, 0, 5, 1, 1, 5, 5, STAT_QUERY_DONE);
        add_row(OP_UPDATE, 32'h3, 1, -7, 3, 0, 0, 0, 0, 0, 0, 0, STAT_QUERY_DONE);
        add_row(OP_QUERY,  32'h0, 0, 0, 0, 0, 0, 10, 0, 0, 0, 0, STAT_QUERY_DONE);
        add_row(OP_UPDATE, 32'h4, 3, 0, 4, 0, 0, 0, 0, 0, 0, 0, STAT_QUERY_DONE);
        add_row(OP_QUERY,  32'h0, 0, 0, 0, 0, 0, 2, 0, 0, 0, 0, STAT_QUERY_DONE);
        add_row(OP_QUERY,  32'h0, 0, 0, 0, 0, 0, 3, 0, 0, 0, 0, STAT_QUERY_DONE);
        add_row(OP_UPDATE, 32'h1, 0, 1, 32767, 0, 0, 0, 0, 0, 0, 0, STAT_QUERY_DONE);
        add_row(OP_QUERY,  32'h0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 0, STAT_QUERY_DONE);
        add_row(OP_UPDATE, 32'h0, 2, 2, 9, 0, 0, 0, 0, 0, 0, 0, STAT_QUERY_DONE);
        add_row(OP_QUERY,  32'h0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 0, STAT_QUERY_DONE);
        add_row(OP_UPDATE, 32'h8000_0000, -1, -1, -1, 0, 0, 0,
                0, 0, 0, 0, STAT_QUERY_DONE);

        foreach (directed_rows[i])
            drive_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].answer);

        // small table, mixed updates and queries
        for (i = 0; i < PHASE1_ITEMS; i++)
        begin
            no_idle = (i >= 400 && i < 550);
            drive_req(random_request(tbl_used < 48 ? 30 : 0, 50), 1'b0, '0);
        end
        no_idle = 1'b0;

        // grow to full
        while (tbl_used < MAX_ENTRIES)
            drive_req(random_request(100, 30), 1'b0, '0);

        // full table: in-place updates, rejected appends, queries
        for (i = 0; i < PHASE3_ITEMS; i++)
            drive_req(random_request(50, 50), 1'b0, '0);

        @(negedge clk);
        req_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (MAX_ENTRIES + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
